FILE: sv/polyline_insert_index_unit_macros.svh
// ============================================================================
// Polyline insert index unit assertion macros
// Shared property macros for the port-level checker.
// ============================================================================
`ifndef POLYLINE_INSERT_INDEX_UNIT_MACROS_SVH
`define POLYLINE_INSERT_INDEX_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PII_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pii assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PII_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pii assertion failed");

`endif

FILE: sv/pii_pkg.sv
// ============================================================================
// Polyline insert index package
// Widths, unit operation codes, accumulator selects and shared structs.
// ============================================================================
package pii_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int IDX_W      = 11;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ROOT_W     = 36;
    localparam int PROD_W     = 2 * ROOT_W;
    localparam int ACC_W      = 68;
    localparam int DIST_W     = ROOT_W + 1;
    localparam int STEP_W     = $clog2(ROOT_W);

    // Shared unit operations.
    localparam logic OP_SQRT = 1'b0;
    localparam logic OP_DIV  = 1'b1;

    // Accumulator selects for multiplier results.
    localparam logic [2:0] ACC_NONE = 3'd0;
    localparam logic [2:0] ACC_D1   = 3'd1;
    localparam logic [2:0] ACC_D2   = 3'd2;
    localparam logic [2:0] ACC_LSQ  = 3'd3;
    localparam logic [2:0] ACC_P1   = 3'd4;
    localparam logic [2:0] ACC_P2   = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [2:0]        sel;
        logic [PROD_W-1:0] prod;
    } mul_out_t;

    typedef struct packed {
        logic start;
        logic op;
    } unit_ctl_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] result;
    } unit_stat_t;

endpackage

FILE: sv/pii_mult.sv
// ============================================================================
// Polyline insert index multiplier
// Registered unsigned multiplier with sign and accumulator tags.
// ============================================================================
module pii_mult (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      issue,
    input  logic [pii_pkg::ROOT_W-1:0] a,
    input  logic [pii_pkg::ROOT_W-1:0] b,
    input  logic                      neg,
    input  logic [2:0]                sel,
    output pii_pkg::mul_out_t         result
);
    import pii_pkg::*;

    logic              valid_reg;
    logic              neg_reg;
    logic [2:0]        sel_reg;
    logic [PROD_W-1:0] prod_reg;

    // Valid flag is the issue strobe, registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= issue;
        end
    end

    // Product and tags are registered.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
        neg_reg  <= neg;
        sel_reg  <= sel;
    end

    assign result = '{valid: valid_reg, neg: neg_reg, sel: sel_reg, prod: prod_reg};

endmodule

FILE: sv/pii_root_div.sv
// ============================================================================
// Polyline insert index root and divide unit
// Shared compare-subtract engine for integer square root and division.
// ============================================================================
module pii_root_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pii_pkg::unit_ctl_t         ctl,
    input  logic [pii_pkg::PROD_W-1:0] x,
    input  logic [pii_pkg::ROOT_W-1:0] d,
    output pii_pkg::unit_stat_t        stat
);
    import pii_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              op_reg;
    logic [PROD_W-1:0] a_reg;
    logic [PROD_W-1:0] b_reg;
    logic [PROD_W-1:0] c_reg;
    logic [ROOT_W-1:0] q_reg;
    logic [PROD_W-1:0] trial;
    logic              ge;

    // One compare and subtract per cycle.
    assign trial = (op_reg == OP_SQRT) ? (b_reg + c_reg) : b_reg;
    assign ge    = (a_reg >= trial);

    // Step counter and handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Remainder, root and quotient registers.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            op_reg <= ctl.op;
            a_reg  <= x;
            q_reg  <= '0;
            if (ctl.op == OP_SQRT)
            begin
                b_reg <= '0;
                c_reg <= PROD_W'(1) << (2 * (ROOT_W - 1));
            end
            else
            begin
                b_reg <= PROD_W'(d) << (ROOT_W - 1);
                c_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                a_reg <= a_reg - trial;
            end
            if (op_reg == OP_SQRT)
            begin
                b_reg <= ge ? ((b_reg >> 1) + c_reg) : (b_reg >> 1);
                c_reg <= c_reg >> 2;
            end
            else
            begin
                b_reg <= b_reg >> 1;
                q_reg <= {q_reg[ROOT_W-2:0], ge};
            end
        end
    end

    assign stat = '{done: done_reg,
                    result: (op_reg == OP_SQRT) ? b_reg[ROOT_W-1:0] : q_reg};

endmodule

FILE: sv/polyline_insert_index_unit.sv
// Throughput: one item at a time, set by the 36-step shared root/divide unit and the
// 15 products through the single registered multiplier. Reset is asynchronous, active low:
// all run state clears to zero and both configuration registers return to 1.
// ============================================================================
// Polyline insert index unit
// Finds the insertion position of a query point in a streamed 3-D polyline.
// ============================================================================
module polyline_insert_index_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic                        cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [pii_pkg::COORD_W-1:0] coord_x,
    input  logic [pii_pkg::COORD_W-1:0] coord_y,
    input  logic [pii_pkg::COORD_W-1:0] coord_z,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pii_pkg::IDX_W-1:0]   insert_index,
    output logic                        rejected
);
    import pii_pkg::*;

    localparam logic REG_REJECT = 1'b0;
    localparam logic REG_DSM    = 1'b1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIFF   = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_MWAIT  = 4'd3;
    localparam logic [3:0] S_BRANCH = 4'd4;
    localparam logic [3:0] S_LAUNCH = 4'd5;
    localparam logic [3:0] S_RUN    = 4'd6;
    localparam logic [3:0] S_TSQ    = 4'd7;
    localparam logic [3:0] S_TSQW   = 4'd8;
    localparam logic [3:0] S_UPD    = 4'd9;
    localparam logic [3:0] S_RESULT = 4'd10;
    localparam logic [3:0] S_DECIDE = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    localparam logic [2:0] P_R1   = 3'd0;
    localparam logic [2:0] P_R2   = 3'd1;
    localparam logic [2:0] P_LEN  = 3'd2;
    localparam logic [2:0] P_T    = 3'd3;
    localparam logic [2:0] P_DIST = 3'd4;

    function automatic logic [ROOT_W-1:0] mag_of(input diff_t v);
        logic [DIFF_W-1:0] m;
        m = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return ROOT_W'(m);
    endfunction

    // Control and architectural state.
    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic                rd_reg;
    logic                dsm_reg;
    coord_t              q_reg    [3];
    coord_t              prev_reg [3];
    coord_t              bs_reg   [3];
    coord_t              be_reg   [3];
    logic [DIST_W-1:0]   best_dist_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [CNT_W-1:0]    vcnt_reg;
    logic                dec_reg;
    logic                drej_reg;
    logic                out_valid_reg;

    // Working registers.
    coord_t              s_reg  [3];
    coord_t              e_reg  [3];
    diff_t               es_reg [3];
    diff_t               qs_reg [3];
    diff_t               eq_reg [3];
    logic signed [ACC_W-1:0] d1_reg;
    logic signed [ACC_W-1:0] d2_reg;
    logic signed [ACC_W-1:0] lsq_reg;
    logic signed [ACC_W-1:0] p1_reg;
    logic signed [ACC_W-1:0] p2_reg;
    logic [IDX_W-1:0]    seg_reg;
    logic                first_reg;
    logic                last_reg;
    logic                final_reg;
    logic [1:0]          k_reg;
    logic [2:0]          j_reg;
    logic [2:0]          phase_reg;
    logic                uop_reg;
    logic [PROD_W-1:0]   ux_reg;
    logic [ROOT_W-1:0]   ud_reg;
    logic [ROOT_W-1:0]   r1_reg;
    logic [ROOT_W-1:0]   t_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [IDX_W-1:0]    cidx_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    logic                res_rej_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic                out_rej_reg;

    coord_t              cur [3];
    logic                in_acc;
    logic                coincident;
    logic                slot_free;
    logic                mul_issue;
    logic [ROOT_W-1:0]   mul_a;
    logic [ROOT_W-1:0]   mul_b;
    logic                mul_neg;
    logic [2:0]          mul_sel;
    mul_out_t            mul_out;
    unit_ctl_t           u_ctl;
    unit_stat_t          u_stat;
    logic signed [ACC_W-1:0] addend;
    logic [PROD_W-1:0]   d1_ext;
    logic [PROD_W-1:0]   rem;

    assign cur[0]     = coord_t'(coord_x);
    assign cur[1]     = coord_t'(coord_y);
    assign cur[2]     = coord_t'(coord_z);
    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && (state_reg == S_IDLE);
    assign coincident = (cur[0] == q_reg[0]) && (cur[1] == q_reg[1]) && (cur[2] == q_reg[2]);
    assign slot_free  = !out_valid_reg || !out_stall;

    // Product schedule: five products per axis, or the square of t.
    always_comb
    begin
        mul_issue = (state_reg == S_MUL) || (state_reg == S_TSQ);
        mul_a     = mag_of(es_reg[k_reg]);
        mul_b     = mag_of(es_reg[k_reg]);
        mul_neg   = 1'b0;
        mul_sel   = ACC_NONE;
        if (state_reg == S_TSQ)
        begin
            mul_a = t_reg;
            mul_b = t_reg;
        end
        else
        begin
            case (j_reg)
                3'd0:
                begin
                    mul_a   = mag_of(qs_reg[k_reg]);
                    mul_b   = mag_of(qs_reg[k_reg]);
                    mul_sel = ACC_D1;
                end
                3'd1:
                begin
                    mul_a   = mag_of(eq_reg[k_reg]);
                    mul_b   = mag_of(eq_reg[k_reg]);
                    mul_sel = ACC_D2;
                end
                3'd2:
                begin
                    mul_sel = ACC_LSQ;
                end
                3'd3:
                begin
                    mul_b   = mag_of(qs_reg[k_reg]);
                    mul_neg = es_reg[k_reg][DIFF_W-1] ^ qs_reg[k_reg][DIFF_W-1];
                    mul_sel = ACC_P1;
                end
                default:
                begin
                    mul_b   = mag_of(eq_reg[k_reg]);
                    mul_neg = es_reg[k_reg][DIFF_W-1] ^ eq_reg[k_reg][DIFF_W-1];
                    mul_sel = ACC_P2;
                end
            endcase
        end
    end

    pii_mult u_mult (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (mul_issue),
        .a      (mul_a),
        .b      (mul_b),
        .neg    (mul_neg),
        .sel    (mul_sel),
        .result (mul_out)
    );

    assign u_ctl = '{start: (state_reg == S_LAUNCH), op: uop_reg};

    pii_root_div u_root_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (u_ctl),
        .x     (ux_reg),
        .d     (ud_reg),
        .stat  (u_stat)
    );

    // Signed addend from the tagged product.
    assign addend = mul_out.neg ? -$signed({1'b0, mul_out.prod[ACC_W-2:0]})
                                :  $signed({1'b0, mul_out.prod[ACC_W-2:0]});
    assign d1_ext = {{(PROD_W-ACC_W){1'b0}}, d1_reg};
    assign rem    = (d1_ext > mul_out.prod) ? (d1_ext - mul_out.prod) : '0;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (mode && (vcnt_reg < CNT_W'(MAX_POINTS)) && !dec_reg && !coincident
                        && (vcnt_reg != '0))
                    begin
                        state_next = S_DIFF;
                    end
                    else if (last)
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_DIFF:   state_next = S_MUL;
            S_MUL:
            begin
                if ((k_reg == 2'd2) && (j_reg == 3'd4))
                begin
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT:  state_next = S_BRANCH;
            S_BRANCH: state_next = final_reg ? S_DECIDE : S_LAUNCH;
            S_LAUNCH: state_next = S_RUN;
            S_RUN:
            begin
                if (u_stat.done)
                begin
                    unique case (phase_reg)
                        P_R1:    state_next = S_LAUNCH;
                        P_R2:    state_next = S_UPD;
                        P_LEN:   state_next = (u_stat.result == '0) ? S_TSQ : S_LAUNCH;
                        P_T:     state_next = S_TSQ;
                        default: state_next = S_UPD;
                    endcase
                end
            end
            S_TSQ:    state_next = S_TSQW;
            S_TSQW:   state_next = S_LAUNCH;
            S_UPD:    state_next = last_reg ? S_RESULT : S_IDLE;
            S_RESULT:
            begin
                if ((vcnt_reg >= CNT_W'(2)) && !dec_reg && dsm_reg)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DECIDE: state_next = S_EMIT;
            S_EMIT:   state_next = slot_free ? S_IDLE : S_EMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    // Architectural state, configuration and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_reg        <= 1'b1;
            dsm_reg       <= 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                q_reg[k]    <= '0;
                prev_reg[k] <= '0;
                bs_reg[k]   <= '0;
                be_reg[k]   <= '0;
            end
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            vcnt_reg      <= '0;
            dec_reg       <= 1'b0;
            drej_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_REJECT: rd_reg  <= cfg_data;
                    REG_DSM:    dsm_reg <= cfg_data;
                    default:    rd_reg  <= rd_reg;
                endcase
            end

            // Input transaction.
            if (in_acc)
            begin
                if (!mode)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        q_reg[k]    <= cur[k];
                        prev_reg[k] <= '0;
                        bs_reg[k]   <= '0;
                        be_reg[k]   <= '0;
                    end
                    best_dist_reg <= '0;
                    best_idx_reg  <= '0;
                    vcnt_reg      <= '0;
                    dec_reg       <= 1'b0;
                    drej_reg      <= 1'b0;
                end
                else if (vcnt_reg < CNT_W'(MAX_POINTS))
                begin
                    if (!dec_reg && coincident)
                    begin
                        dec_reg      <= 1'b1;
                        drej_reg     <= rd_reg;
                        best_idx_reg <= rd_reg ? '0 : IDX_W'(vcnt_reg);
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        prev_reg[k] <= cur[k];
                    end
                    vcnt_reg <= vcnt_reg + 1'b1;
                end
            end

            // Keep the best segment so far; ties keep the earlier one.
            if ((state_reg == S_UPD) && (first_reg || (dist_reg < best_dist_reg)))
            begin
                best_dist_reg <= dist_reg;
                best_idx_reg  <= cidx_reg;
                if (dsm_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        bs_reg[k] <= s_reg[k];
                        be_reg[k] <= e_reg[k];
                    end
                end
            end

            // Output register.
            if ((state_reg == S_EMIT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath working registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s_reg[k] <= prev_reg[k];
                e_reg[k] <= cur[k];
            end
            seg_reg   <= IDX_W'(vcnt_reg) - 1'b1;
            first_reg <= (vcnt_reg == CNT_W'(1));
            last_reg  <= last;
            final_reg <= 1'b0;
        end

        // Accumulate products as they leave the multiplier.
        if (mul_out.valid)
        begin
            case (mul_out.sel)
                ACC_D1:  d1_reg  <= d1_reg + addend;
                ACC_D2:  d2_reg  <= d2_reg + addend;
                ACC_LSQ: lsq_reg <= lsq_reg + addend;
                ACC_P1:  p1_reg  <= p1_reg + addend;
                ACC_P2:  p2_reg  <= p2_reg + addend;
                default: d1_reg  <= d1_reg;
            endcase
        end

        case (state_reg)
            S_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    es_reg[k] <= DIFF_W'(e_reg[k]) - DIFF_W'(s_reg[k]);
                    qs_reg[k] <= DIFF_W'(q_reg[k]) - DIFF_W'(s_reg[k]);
                    eq_reg[k] <= DIFF_W'(e_reg[k]) - DIFF_W'(q_reg[k]);
                end
                d1_reg  <= '0;
                d2_reg  <= '0;
                lsq_reg <= '0;
                p1_reg  <= '0;
                p2_reg  <= '0;
                k_reg   <= '0;
                j_reg   <= '0;
            end
            S_MUL:
            begin
                if (j_reg == 3'd4)
                begin
                    j_reg <= '0;
                    k_reg <= k_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            S_BRANCH:
            begin
                uop_reg <= OP_SQRT;
                if (dsm_reg)
                begin
                    ux_reg    <= d1_ext;
                    phase_reg <= P_R1;
                    cidx_reg  <= seg_reg;
                end
                else if (!p1_reg[ACC_W-1] && !p2_reg[ACC_W-1])
                begin
                    ux_reg    <= {{(PROD_W-ACC_W){1'b0}}, lsq_reg};
                    phase_reg <= P_LEN;
                    cidx_reg  <= seg_reg + 1'b1;
                end
                else if (p1_reg[ACC_W-1])
                begin
                    ux_reg    <= d1_ext;
                    phase_reg <= P_DIST;
                    cidx_reg  <= seg_reg;
                end
                else
                begin
                    ux_reg    <= {{(PROD_W-ACC_W){1'b0}}, d2_reg};
                    phase_reg <= P_DIST;
                    cidx_reg  <= seg_reg + IDX_W'(2);
                end
            end
            S_RUN:
            begin
                if (u_stat.done)
                begin
                    case (phase_reg)
                        P_R1:
                        begin
                            r1_reg    <= u_stat.result;
                            ux_reg    <= {{(PROD_W-ACC_W){1'b0}}, d2_reg};
                            uop_reg   <= OP_SQRT;
                            phase_reg <= P_R2;
                        end
                        P_R2:
                        begin
                            dist_reg <= DIST_W'(r1_reg) + DIST_W'(u_stat.result);
                        end
                        P_LEN:
                        begin
                            // A zero-length segment projects to zero.
                            t_reg     <= '0;
                            ux_reg    <= {{(PROD_W-ACC_W){1'b0}}, p1_reg};
                            ud_reg    <= u_stat.result;
                            uop_reg   <= OP_DIV;
                            phase_reg <= P_T;
                        end
                        P_T:
                        begin
                            t_reg <= u_stat.result;
                        end
                        default:
                        begin
                            dist_reg <= DIST_W'(u_stat.result);
                        end
                    endcase
                end
            end
            S_TSQW:
            begin
                ux_reg    <= rem;
                uop_reg   <= OP_SQRT;
                phase_reg <= P_DIST;
            end
            S_RESULT:
            begin
                res_rej_reg <= 1'b0;
                if (vcnt_reg < CNT_W'(2))
                begin
                    res_idx_reg <= IDX_W'(vcnt_reg);
                end
                else if (dec_reg)
                begin
                    res_idx_reg <= best_idx_reg;
                    res_rej_reg <= drej_reg;
                end
                else if (dsm_reg)
                begin
                    // Project the query onto the kept segment.
                    for (int k = 0; k < 3; k++)
                    begin
                        s_reg[k] <= bs_reg[k];
                        e_reg[k] <= be_reg[k];
                    end
                    final_reg <= 1'b1;
                end
                else
                begin
                    res_idx_reg <= best_idx_reg;
                end
            end
            S_DECIDE:
            begin
                res_rej_reg <= 1'b0;
                if (p1_reg[ACC_W-1] || (p1_reg == '0))
                begin
                    res_idx_reg <= best_idx_reg;
                end
                else if (p2_reg[ACC_W-1] || (p2_reg == '0))
                begin
                    res_idx_reg <= best_idx_reg + IDX_W'(2);
                end
                else
                begin
                    res_idx_reg <= best_idx_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_idx_reg <= res_idx_reg;
                    out_rej_reg <= res_rej_reg;
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign insert_index = out_idx_reg;
    assign rejected     = out_rej_reg;

endmodule

FILE: sv/pii_checker.sv
// ============================================================================
// Polyline insert index checker
// Port-level assertions for the insert index unit, attached by bind.
// ============================================================================
`include "polyline_insert_index_unit_macros.svh"

module pii_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic        last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] insert_index,
    input logic        rejected
);

    // A rejection always carries index zero.
    `PII_ASSERT_SAME(a_rej_zero, out_valid && rejected, insert_index == 11'd0)

    // A stalled result transaction holds.
    `PII_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(insert_index) && $stable(rejected))

    // A transaction with last keeps the block busy while the result is formed.
    `PII_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && last, in_stall)

    // A query without last leaves the input free again in the following cycle.
    `PII_ASSERT_NEXT(a_query_quick, in_valid && !in_stall && !mode && !last, !in_stall)

endmodule

bind polyline_insert_index_unit pii_checker u_pii_checker (.*);

FILE: bench/polyline_insert_index_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Polyline insert index unit testbench
// Streams query points and polyline vertices into the unit under several
// register settings and idle patterns, predicts each insertion result with
// an exact-arithmetic model of the search and compares every result.
// ============================================================================
module polyline_insert_index_unit_tb;

    localparam int   VERTEX_CAP  = 1024;
    localparam int   QUIET_WAIT  = 250;
    localparam int   CYCLE_LIMIT = 2500000;
    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_VERTEX = 1'b1;
    localparam logic REG_REJECT  = 1'b0;
    localparam logic REG_SUMMODE = 1'b1;

    typedef logic signed [131:0] wide_t;
    typedef longint vec3_t [3];

    typedef struct {
        logic [pii_pkg::IDX_W-1:0] idx;
        logic                      rej;
    } insert_result_t;

    // Scoreboard: exact predictor of the search plus the queue of results.
    class insert_scoreboard;
        logic           reject_dup;
        logic           sum_mode;
        longint         query_pt [3];
        longint         prev_vtx [3];
        longint         best_ends [6];
        logic [63:0]    best_dist;
        int unsigned    best_idx;
        int unsigned    vtx_count;
        bit             decided;
        bit             decided_rej;
        insert_result_t pending_q [$];
        int             mismatches;

        function new();
            reject_dup = 1'b1;
            sum_mode   = 1'b1;
            mismatches = 0;
            foreach (query_pt[k]) query_pt[k] = 0;
            clear_run();
        endfunction

        function void clear_run();
            foreach (prev_vtx[k]) prev_vtx[k] = 0;
            foreach (best_ends[k]) best_ends[k] = 0;
            best_dist   = 0;
            best_idx    = 0;
            vtx_count   = 0;
            decided     = 0;
            decided_rej = 0;
        endfunction

        function void set_reg(logic idx, logic val);
            if (idx == REG_REJECT) reject_dup = val;
            else sum_mode = val;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        static function logic [63:0] isqrt(logic [131:0] x);
            logic [63:0]  r;
            logic [131:0] c;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                c = {68'd0, r | (64'd1 << b)};
                if (c * c <= x) r = c[63:0];
            end
            return r;
        endfunction

        static function wide_t dot3(vec3_t u, vec3_t v);
            wide_t s;
            s = 0;
            for (int k = 0; k < 3; k++) s += wide_t'(u[k]) * wide_t'(v[k]);
            return s;
        endfunction

        // Scores one segment against the best one so far.
        function void score_segment(vec3_t s, vec3_t e, int unsigned i, bit first);
            vec3_t       es, qs, eq;
            wide_t       d1, d2, p1, p2, t, tsq, rem;
            logic [63:0] seg_dist, len;
            int unsigned idx;
            for (int k = 0; k < 3; k++)
            begin
                es[k] = e[k] - s[k];
                qs[k] = query_pt[k] - s[k];
                eq[k] = e[k] - query_pt[k];
            end
            d1 = dot3(qs, qs);
            d2 = dot3(eq, eq);
            if (sum_mode)
            begin
                seg_dist = isqrt(d1) + isqrt(d2);
                if (first || seg_dist < best_dist)
                begin
                    best_dist = seg_dist;
                    best_idx  = i;
                    for (int k = 0; k < 3; k++)
                    begin
                        best_ends[k]     = s[k];
                        best_ends[3 + k] = e[k];
                    end
                end
                return;
            end
            p1 = dot3(es, qs);
            p2 = dot3(es, eq);
            if (p1 >= 0 && p2 >= 0)
            begin
                // Within the segment: perpendicular distance.
                len      = isqrt(dot3(es, es));
                t        = (len == 0) ? wide_t'(0) : p1 / wide_t'({68'd0, len});
                tsq      = t * t;
                rem      = (d1 > tsq) ? d1 - tsq : wide_t'(0);
                seg_dist = isqrt(rem);
                idx      = i + 1;
            end
            else if (p1 < 0)
            begin
                seg_dist = isqrt(d1);
                idx      = i;
            end
            else
            begin
                seg_dist = isqrt(d2);
                idx      = i + 2;
            end
            if (first || seg_dist < best_dist)
            begin
                best_dist = seg_dist;
                best_idx  = idx;
            end
        endfunction

        // Projects the query onto the kept segment at the end of a run.
        function int unsigned sum_mode_index();
            vec3_t es, qs, eq;
            for (int k = 0; k < 3; k++)
            begin
                es[k] = best_ends[3 + k] - best_ends[k];
                qs[k] = query_pt[k] - best_ends[k];
                eq[k] = best_ends[3 + k] - query_pt[k];
            end
            if (dot3(es, qs) <= 0) return best_idx;
            if (dot3(es, eq) <= 0) return best_idx + 2;
            return best_idx + 1;
        endfunction

        // Notes one accepted input transaction.
        function void note_input(logic m, longint x, longint y, longint z, logic l);
            vec3_t          cur, prv;
            int unsigned    i, idx;
            insert_result_t res;
            cur[0] = x;
            cur[1] = y;
            cur[2] = z;
            if (m == MODE_QUERY)
            begin
                foreach (query_pt[k]) query_pt[k] = cur[k];
                clear_run();
            end
            else if (vtx_count < VERTEX_CAP)
            begin
                i = vtx_count;
                if (!decided)
                begin
                    if (cur[0] == query_pt[0] && cur[1] == query_pt[1] &&
                        cur[2] == query_pt[2])
                    begin
                        decided     = 1;
                        decided_rej = reject_dup;
                        best_idx    = decided_rej ? 0 : i;
                    end
                    else if (i >= 1)
                    begin
                        foreach (prv[k]) prv[k] = prev_vtx[k];
                        score_segment(prv, cur, i - 1, i == 1);
                    end
                end
                foreach (prev_vtx[k]) prev_vtx[k] = cur[k];
                vtx_count = i + 1;
            end
            if (!l) return;
            res.rej = 1'b0;
            if (vtx_count < 2) idx = vtx_count;
            else if (decided)
            begin
                idx     = best_idx;
                res.rej = decided_rej;
            end
            else if (sum_mode) idx = sum_mode_index();
            else idx = best_idx;
            res.idx = idx[pii_pkg::IDX_W-1:0];
            pending_q = {pending_q, res};
        endfunction

        // Checks one accepted result transaction.
        function void check(logic [pii_pkg::IDX_W-1:0] idx, logic rej);
            insert_result_t exp_r;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d rejected %0b", idx, rej);
                return;
            end
            exp_r = pending_q.pop_front();
            if (idx !== exp_r.idx || rej !== exp_r.rej)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected index %0d rejected %0b, got %0d %0b",
                             exp_r.idx, exp_r.rej, idx, rej);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic                        cfg_index;
    logic                        cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic                        mode;
    logic [pii_pkg::COORD_W-1:0] coord_x;
    logic [pii_pkg::COORD_W-1:0] coord_y;
    logic [pii_pkg::COORD_W-1:0] coord_z;
    logic                        last;
    logic                        out_valid;
    logic                        out_stall;
    logic [pii_pkg::IDX_W-1:0]   insert_index;
    logic                        rejected;

    insert_scoreboard sb;
    int               idle_pct;
    int               stall_pct;
    int               items_sent;
    int               cycles;

    polyline_insert_index_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .insert_index (insert_index),
        .rejected     (rejected)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check(insert_index, rejected);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sends one input transaction, with random idle cycles before it.
    task automatic send_item(input logic m, input longint x, input longint y,
                             input longint z, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        coord_x  <= x[31:0];
        coord_y  <= y[31:0];
        coord_z  <= z[31:0];
        last     <= l;
        do @(posedge clk); while (in_stall);
        sb.note_input(m, x, y, z, l);
        items_sent++;
    endtask

    // Waits until every expected result is in and the unit has settled.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (QUIET_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Random coordinate: full range, an extreme, or near a base point.
    function automatic longint rnd_coord(longint base);
        longint v;
        case ($urandom_range(5))
            0: v = longint'($signed($urandom()));
            1:
            begin
                case ($urandom_range(3))
                    0: v = -64'sd2147483648;
                    1: v = 64'sd2147483647;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = base + longint'($urandom_range(65535)) - 32768;
        endcase
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v;
    endfunction

    // One random run: mostly a well-formed polyline, sometimes noise.
    task automatic random_run();
        longint q [3];
        longint p [3];
        longint v [3];
        int     n;
        int     kind;
        kind = $urandom_range(99);
        for (int k = 0; k < 3; k++) q[k] = rnd_coord(0);
        if (kind < 80)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            send_item(MODE_QUERY, q[0], q[1], q[2], 1'b0);
            for (int k = 0; k < 3; k++) p[k] = q[k];
            for (int j = 0; j < n; j++)
            begin
                case ($urandom_range(9))
                    0: for (int k = 0; k < 3; k++) v[k] = q[k];
                    1: for (int k = 0; k < 3; k++) v[k] = p[k];
                    default: for (int k = 0; k < 3; k++) v[k] = rnd_coord(q[k]);
                endcase
                send_item(MODE_VERTEX, v[0], v[1], v[2], j == n - 1);
                for (int k = 0; k < 3; k++) p[k] = v[k];
            end
        end
        else if (kind < 87)
            send_item(MODE_QUERY, q[0], q[1], q[2], 1'b1);
        else if (kind < 94)
            send_item(MODE_VERTEX, q[0], q[1], q[2], 1'($urandom_range(1)));
        else
        begin
            // A run that is abandoned without a last item.
            send_item(MODE_QUERY, q[0], q[1], q[2], 1'b0);
            send_item(MODE_VERTEX, rnd_coord(q[0]), rnd_coord(q[1]), rnd_coord(q[2]), 1'b0);
        end
    endtask

    initial
    begin
        sb         = new();
        idle_pct   = 0;
        stall_pct  = 0;
        items_sent = 0;
        cycles     = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = 1'b0;
        cfg_data   = 1'b0;
        in_valid   = 1'b0;
        mode       = 1'b0;
        coord_x    = '0;
        coord_y    = '0;
        coord_z    = '0;
        last       = 1'b0;
        out_stall  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty run, extremes, zero-length segment, coincident points.
        send_item(MODE_QUERY, 0, 0, 0, 1'b1);
        send_item(MODE_QUERY, 1000, 2000, -3000, 1'b0);
        send_item(MODE_VERTEX, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 1'b0);
        send_item(MODE_VERTEX, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 1'b0);
        send_item(MODE_VERTEX, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 1'b0);
        send_item(MODE_VERTEX, 0, 0, 0, 1'b1);
        send_item(MODE_QUERY, 5, 6, 7, 1'b0);
        send_item(MODE_VERTEX, 5, 6, 7, 1'b1);
        send_item(MODE_QUERY, 5, 6, 7, 1'b0);
        send_item(MODE_VERTEX, 0, 0, 0, 1'b0);
        send_item(MODE_VERTEX, 5, 6, 7, 1'b0);
        send_item(MODE_VERTEX, 9, 9, 9, 1'b1);
        send_item(MODE_VERTEX, -4096, 8192, 0, 1'b0);
        send_item(MODE_VERTEX, 4096, 8192, 0, 1'b1);
        wait_quiet();
        write_reg(REG_REJECT, 1'b0);
        write_reg(REG_SUMMODE, 1'b0);
        send_item(MODE_QUERY, 0, 4096, 0, 1'b0);
        send_item(MODE_VERTEX, -8192, 0, 0, 1'b0);
        send_item(MODE_VERTEX, -8192, 0, 0, 1'b0);
        send_item(MODE_VERTEX, 8192, 0, 0, 1'b0);
        send_item(MODE_VERTEX, 0, 4096, 0, 1'b0);
        send_item(MODE_VERTEX, 20000, 1, 1, 1'b1);
        wait_quiet();

        // Random phases over all register settings and idle patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_REJECT, ph[0]);
            write_reg(REG_SUMMODE, ph[1]);
            case ((ph + ph / 4) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            items_sent = 0;
            while (items_sent < 74) random_run();
            wait_quiet();
        end

        idle_pct  = 0;
        stall_pct = 0;
        wait_quiet();
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
